// ----- src/mpa_pkg.sv -----
// Shared types and constants for the max pooling with argmax block.
// Used by every module under src; depends on nothing.
`default_nettype none

package mpa_pkg;

  localparam int ROW_COUNT_W = 13;
  localparam int COL_COUNT_W = 11;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int SAMPLE_W    = 16;
  localparam int ROW_OUT_W   = 12;
  localparam int COL_OUT_W   = 10;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  // One window store entry: running maximum and where it sits
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [ROW_OUT_W-1:0]       row;
    logic [COL_OUT_W-1:0]       col;
  } entry_t;

  // Position info of the sample being taken
  typedef struct packed {
    logic                 in_win;
    logic                 first;
    logic                 emit;
    logic                 last;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } pos_info_t;

  typedef struct packed {
    entry_t best;
    logic   last;
  } result_t;

endpackage

`default_nettype wire

// ----- src/max_pool_with_argmax_unit.sv -----
// Max pooling with argmax: one beat per clock in while not stalled, one result per complete window out.
// A taken sample passes the compare-stage registers, then the result queue, before its result (if any) shows.
// Throughput: one sample per cycle unless in_stall_o is high, set by the window store read-modify-write.
// Reset clears positions, queue and stage control, and sets both map sizes to 64 (or the limit if smaller).
// The window store is not cleared; each window is seeded by its own first sample.
`default_nettype none

module max_pool_with_argmax_unit import mpa_pkg::*; #(
  parameter int POOL     = 2,
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration writes
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  // sample channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0]      max_value_o,
  output logic [ROW_OUT_W-1:0]            max_row_o,
  output logic [COL_OUT_W-1:0]            max_col_o,
  output logic                            last_o
);

  // One store entry per window column; keep at least one entry
  localparam int SLOTS = (MAX_COLS / POOL > 0) ? (MAX_COLS / POOL) : 1;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [ROW_COUNT_W-1:0] ROWS_RST =
    (MAX_ROWS < 64) ? ROW_COUNT_W'(MAX_ROWS) : ROW_COUNT_W'(64);
  localparam logic [COL_COUNT_W-1:0] COLS_RST =
    (MAX_COLS < 64) ? COL_COUNT_W'(MAX_COLS) : COL_COUNT_W'(64);

  // Clamp a written size: zero counts as one, anything above the limit as the limit
  function automatic logic [ROW_COUNT_W-1:0] eff_rows(input logic [ROW_COUNT_W-1:0] v);
    logic [ROW_COUNT_W-1:0] r;
    if (v == '0) r = ROW_COUNT_W'(1);
    else if (32'(v) > 32'(MAX_ROWS)) r = ROW_COUNT_W'(MAX_ROWS);
    else r = v;
    return r;
  endfunction

  function automatic logic [COL_COUNT_W-1:0] eff_cols(input logic [COL_COUNT_W-1:0] v);
    logic [COL_COUNT_W-1:0] c;
    if (v == '0) c = COL_COUNT_W'(1);
    else if (32'(v) > 32'(MAX_COLS)) c = COL_COUNT_W'(MAX_COLS);
    else c = v;
    return c;
  endfunction

  logic [ROW_COUNT_W-1:0] rows_q;
  logic [COL_COUNT_W-1:0] cols_q;
  logic                   acc, room, s1_valid, res_valid;
  pos_info_t              info;
  logic [AW-1:0]          addr;
  result_t                res, head;

  // Hold the clamped sizes; the user must write only while the block is idle (the block does not enforce it)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_COUNT: rows_q <= eff_rows(cfg_wdata_i);
        CFG_COL_COUNT: cols_q <= eff_cols(cfg_wdata_i[COL_COUNT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stall the sample side only when the result queue could overflow
  assign in_stall_o = !room;
  assign acc        = in_valid_i && !in_stall_o;

  // Position of the incoming beat and the window column it updates
  mpa_pos #(
    .POOL     (POOL),
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_pos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (acc),
    .rows_i (rows_q),
    .cols_i (cols_q),
    .info_o (info),
    .addr_o (addr)
  );

  // Read the window entry at accept, compare and write back in the following cycle
  mpa_wstore #(
    .AW    (AW),
    .DEPTH (SLOTS)
  ) u_wstore (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .info_i      (info),
    .addr_i      (addr),
    .sample_i    (sample_i),
    .s1_valid_o  (s1_valid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Decouple finished windows from the output stall
  mpa_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pend_i      (s1_valid),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign max_value_o = head.best.value;
  assign max_row_o   = head.best.row;
  assign max_col_o   = head.best.col;
  assign last_o      = head.last;

endmodule

`default_nettype wire

// ----- src/mpa_pos.sv -----
// Raster position tracker: row, column, window phases and window column index.
// Depends on mpa_pkg.
`default_nettype none

module mpa_pos import mpa_pkg::*; #(
  parameter int POOL     = 2,
  parameter int MAX_ROWS = 4096,
  parameter int MAX_COLS = 1024,
  parameter int AW       = 9
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  wire logic [ROW_COUNT_W-1:0] rows_i,
  input  wire logic [COL_COUNT_W-1:0] cols_i,
  output pos_info_t                   info_o,
  output logic [AW-1:0]               addr_o
);

  localparam int RPOS_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CPOS_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PH_W   = $clog2(POOL);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(POOL - 1);

  logic [RPOS_W-1:0] row_q, row_d, rbase_q, rbase_d;
  logic [CPOS_W-1:0] col_q, col_d, cbase_q, cbase_d;
  logic [PH_W-1:0]   rph_q, rph_d, cph_q, cph_d;
  logic [AW-1:0]     wc_q, wc_d;
  logic              col_wrap, row_wrap;

  assign col_wrap = (32'(col_q) + 32'd1) >= 32'(cols_i);
  assign row_wrap = (32'(row_q) + 32'd1) >= 32'(rows_i);

  always_comb begin
    row_d   = row_q;
    rbase_d = rbase_q;
    rph_d   = rph_q;
    col_d   = col_q + CPOS_W'(1);
    cbase_d = cbase_q;
    cph_d   = cph_q;
    wc_d    = wc_q;
    if (col_wrap) begin
      col_d   = '0;
      cbase_d = '0;
      cph_d   = '0;
      wc_d    = '0;
      if (row_wrap) begin
        row_d   = '0;
        rbase_d = '0;
        rph_d   = '0;
      end else begin
        row_d = row_q + RPOS_W'(1);
        if (rph_q == PH_LAST) begin
          rph_d   = '0;
          rbase_d = rbase_q + RPOS_W'(POOL);
        end else begin
          rph_d = rph_q + PH_W'(1);
        end
      end
    end else if (cph_q == PH_LAST) begin
      cph_d   = '0;
      cbase_d = cbase_q + CPOS_W'(POOL);
      wc_d    = wc_q + AW'(1);
    end else begin
      cph_d = cph_q + PH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      rbase_q <= '0;
      rph_q   <= '0;
      col_q   <= '0;
      cbase_q <= '0;
      cph_q   <= '0;
      wc_q    <= '0;
    end else if (adv_i) begin
      row_q   <= row_d;
      rbase_q <= rbase_d;
      rph_q   <= rph_d;
      col_q   <= col_d;
      cbase_q <= cbase_d;
      cph_q   <= cph_d;
      wc_q    <= wc_d;
    end
  end

  always_comb begin
    info_o.in_win = ((32'(rbase_q) + 32'(POOL)) <= 32'(rows_i)) &&
                    ((32'(cbase_q) + 32'(POOL)) <= 32'(cols_i));
    info_o.first  = (rph_q == '0) && (cph_q == '0);
    info_o.emit   = (rph_q == PH_LAST) && (cph_q == PH_LAST);
    info_o.last   = ((32'(rbase_q) + 32'(2 * POOL)) > 32'(rows_i)) &&
                    ((32'(cbase_q) + 32'(2 * POOL)) > 32'(cols_i));
    info_o.row    = ROW_OUT_W'(row_q);
    info_o.col    = COL_OUT_W'(col_q);
  end

  assign addr_o = wc_q;

endmodule

`default_nettype wire

// ----- src/mpa_wstore.sv -----
// Window store memory with its read-modify-write compare stage.
// Depends on mpa_pkg.
`default_nettype none

module mpa_wstore import mpa_pkg::*; #(
  parameter int AW    = 9,
  parameter int DEPTH = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       acc_i,
  input  pos_info_t                       info_i,
  input  wire logic [AW-1:0]              addr_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  output logic                            s1_valid_o,
  output logic                            res_valid_o,
  output result_t                         res_o
);

  entry_t mem [DEPTH];

  entry_t                     rd_q, fwd_q, cur, nxt;
  logic                       fwd_sel_q;
  logic                       s1_valid_q;
  pos_info_t                  s1_info_q;
  logic [AW-1:0]              s1_addr_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       wen, upd;

  // Take the entry just written back when it is the one being read
  assign cur = fwd_sel_q ? fwd_q : rd_q;
  assign upd = s1_info_q.first || ($signed(s1_sample_q) > $signed(cur.value));

  always_comb begin
    nxt = cur;
    if (upd) begin
      nxt.value = s1_sample_q;
      nxt.row   = s1_info_q.row;
      nxt.col   = s1_info_q.col;
    end
  end

  assign wen = s1_valid_q && s1_info_q.in_win;

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q <= mem[addr_i];
    end
    if (wen) begin
      mem[s1_addr_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_info_q   <= info_i;
      s1_addr_q   <= addr_i;
      s1_sample_q <= sample_i;
      fwd_sel_q   <= wen && (s1_addr_q == addr_i);
      fwd_q       <= nxt;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign res_valid_o = wen && s1_info_q.emit;
  assign res_o.best  = nxt;
  assign res_o.last  = s1_info_q.last;

endmodule

`default_nettype wire

// ----- src/mpa_obuf.sv -----
// Three-entry result queue between the compare stage and the output channel.
// Depends on mpa_pkg.
`default_nettype none

module mpa_obuf import mpa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  result_t   push_data_i,
  input  wire logic pend_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output result_t   head_o
);

  localparam int DEPTH = 3;
  localparam logic [1:0] PTR_LAST = 2'(DEPTH - 1);

  result_t    buf_q [DEPTH];
  logic [1:0] wr_ptr_q, rd_ptr_q, count_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = buf_q[rd_ptr_q];
  // Keep a slot for the beat that may still come out of the compare stage
  assign room_o      = (3'(count_q) + 3'(pend_i)) <= 3'(DEPTH - 1);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- tb/max_pool_with_argmax_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for max_pool_with_argmax_unit: 2x2 max pooling with argmax.
// Depends on mpa_pkg and the unit itself; a predictor in this file computes every window.

module max_pool_with_argmax_unit_tb;
  import mpa_pkg::*;

  localparam int POOL         = 2;
  localparam int MAX_COLS     = 1024;
  localparam int MAX_ROWS     = 4096;
  localparam int WIN_SLOTS    = MAX_COLS / POOL;
  localparam int SETTLE_CYCLES = 4;       // slack for the pipe after the last window
  localparam int HOLD_CYCLES  = 300;      // long output hold-off to fill the unit
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOWN_ERRORS = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // DUT ports; every input starts at a known value
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i   = CFG_ROW_COUNT;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] max_value_o;
  logic [ROW_OUT_W-1:0]       max_row_o;
  logic [COL_OUT_W-1:0]       max_col_o;
  logic                       last_o;

  // Predictor state: sizes as written, next raster position, per-column window store
  logic [ROW_COUNT_W-1:0] map_rows_cfg;
  logic [COL_COUNT_W-1:0] map_cols_cfg;
  logic [ROW_OUT_W-1:0]   next_row;
  logic [COL_OUT_W-1:0]   next_col;
  entry_t                 window_model [WIN_SLOTS];
  result_t                expected_windows [$];

  // Idling knobs and bookkeeping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requested = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int samples_sent   = 0;
  int windows_seen   = 0;
  int size_writes    = 0;

  max_pool_with_argmax_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .max_value_o(max_value_o),
    .max_row_o  (max_row_o),
    .max_col_o  (max_col_o),
    .last_o     (last_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: end the run if the unit hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d windows still pending",
               cycle_count, expected_windows.size());
      $display("[max_pool_with_argmax_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted here when one is requested.
  // One nonblocking write of out_stall_i per edge.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_requested) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Result checker: compare every accepted beat against the oldest predicted window
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      windows_seen <= windows_seen + 1;
      if (expected_windows.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected window: value %0d row %0d col %0d last %0b",
                   max_value_o, max_row_o, max_col_o, last_o);
      end else begin
        want = expected_windows.pop_front();
        if (max_value_o !== want.best.value || max_row_o !== want.best.row ||
            max_col_o !== want.best.col || last_o !== want.last) begin
          error_count = error_count + 1;
          if (error_count <= SHOWN_ERRORS) begin
            $display("window mismatch: expected value %0d row %0d col %0d last %0b,",
                     want.best.value, want.best.row, want.best.col, want.last);
            $display("  got value %0d row %0d col %0d last %0b",
                     max_value_o, max_row_o, max_col_o, last_o);
          end
        end
      end
    end
  end

  function automatic int clamp_size(int v, int limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  // Advance the predictor by one accepted sample; queue a window when its corner arrives
  function automatic void pool_sample(logic signed [SAMPLE_W-1:0] s);
    int rows, cols, r, c, wr, wc;
    result_t win;
    rows = clamp_size(int'(map_rows_cfg), MAX_ROWS);
    cols = clamp_size(int'(map_cols_cfg), MAX_COLS);
    r  = int'(next_row);
    c  = int'(next_col);
    wr = r / POOL;
    wc = c / POOL;
    if (wr < rows / POOL && wc < cols / POOL) begin
      // The first sample seeds the window; later ones replace it only when strictly larger
      if (r % POOL == 0 && c % POOL == 0 ||
          $signed(s) > $signed(window_model[wc].value)) begin
        window_model[wc].value = s;
        window_model[wc].row   = r[ROW_OUT_W-1:0];
        window_model[wc].col   = c[COL_OUT_W-1:0];
      end
      if (r % POOL == POOL - 1 && c % POOL == POOL - 1) begin
        win.best = window_model[wc];
        win.last = (wr == rows / POOL - 1) && (wc == cols / POOL - 1);
        expected_windows.push_back(win);
      end
    end
    if (c + 1 >= cols) begin
      next_col = '0;
      next_row = (r + 1 >= rows) ? '0 : ROW_OUT_W'(r + 1);
    end else begin
      next_col = COL_OUT_W'(c + 1);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return SAMPLE_W'(int'($urandom_range(0, 4)) - 2);  // dense ties around zero
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one beat, idling first as the sender mode asks; predict at acceptance
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    pool_sample(s);
    samples_sent++;
  endtask

  // Pause the sender until every predicted window has come back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both size registers, rows first and then columns; call only while drained
  task automatic set_map_size(input int rows, input int cols);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROW_COUNT;
    cfg_wdata_i <= CFG_DATA_W'(rows);
    @(posedge clk_i);
    map_rows_cfg = ROW_COUNT_W'(rows);
    cfg_idx_i   <= CFG_COL_COUNT;
    cfg_wdata_i <= CFG_DATA_W'(cols);
    @(posedge clk_i);
    map_cols_cfg = COL_COUNT_W'(cols);
    cfg_we_i    <= 1'b0;
    size_writes++;
  endtask

  // Finish the current map (or send a whole one from the origin)
  task automatic send_until_map_start();
    do send_sample(random_sample()); while (next_row != '0 || next_col != '0);
  endtask

  // Stop at the top left of a band: every window after a size change gets seeded
  task automatic pad_to_band_start();
    while (next_col != '0 || next_row % POOL != 0) send_sample(random_sample());
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
                     ((mode == IDLE_BOTH) ? 9 : 50) : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
                     ((mode == IDLE_BOTH) ? 9 : 50) : 0;
  endtask

  // Reset sizes are 64 x 64: two rows yield the first band of windows
  task automatic test_default_size();
    repeat (2 * 64) send_sample(random_sample());
    drain();
  endtask

  // Extremes, ties kept on the earlier sample, and the last-window flag on a 4 x 4 map
  task automatic test_directed_windows();
    logic signed [SAMPLE_W-1:0] map4 [16];
    map4 = '{16'sh8000, 16'sh8000, 16'sd5,    16'sh7FFF,
             16'sh8000, 16'sh8000, 16'sh7FFF, -16'sd1,
             16'sh8000, 16'sh8000, 16'sd0,    16'sd0,
             16'sh8000, 16'sh7FFF, 16'sd0,    16'sd0};
    set_map_size(4, 4);
    send_until_map_start();
    foreach (map4[i]) send_sample(map4[i]);
    drain();
  endtask

  // Zero sizes, maps narrower or shorter than a window, odd sizes with a cut-off edge
  task automatic test_small_maps();
    int sizes [5][2];
    sizes = '{'{0, 0}, '{1, 5}, '{5, 1}, '{3, 5}, '{2, 3}};
    foreach (sizes[i]) begin
      set_map_size(sizes[i][0], sizes[i][1]);
      send_until_map_start();
      drain();
    end
  endtask

  // Size change with the position left beyond the new bound, for columns and for rows
  task automatic test_mid_map_change();
    set_map_size(4, 8);
    repeat (6) send_sample(random_sample());
    drain();
    set_map_size(4, 4);
    send_until_map_start();
    drain();
    set_map_size(8, 4);
    repeat (24) send_sample(random_sample());
    drain();
    set_map_size(4, 4);
    send_until_map_start();
    drain();
  endtask

  // Sizes above the limits: start a tall map and close it on a short one,
  // then start a wide map and fold its first row into a 4 x 4 map
  task automatic test_size_limits();
    set_map_size(8191, 2);
    repeat (6) send_sample(random_sample());
    drain();
    set_map_size(4, 2);
    send_until_map_start();
    drain();
    set_map_size(4097, 2047);
    repeat (40) send_sample(random_sample());
    drain();
    set_map_size(4, 4);
    send_until_map_start();
    drain();
  endtask

  // Hold the output for a long stretch while beats keep coming, so the input stalls
  task automatic test_backpressure();
    set_idle_mode(IDLE_NONE);
    set_map_size(6, 8);
    hold_requested++;
    repeat (40) send_sample(random_sample());
    pad_to_band_start();
    drain();
  endtask

  // Random sizes and content under each idle mode; sizes change at band starts
  task automatic test_random_phases();
    int rows, cols;
    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      set_idle_mode(idle_mode_e'(m));
      repeat (2) begin
        rows = $urandom_range(0, 10);
        cols = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        set_map_size(rows, cols);
        repeat ($urandom_range(10, 20)) send_sample(random_sample());
        pad_to_band_start();
        drain();
      end
    end
    set_idle_mode(IDLE_NONE);
  endtask

  initial begin
    map_rows_cfg = ROW_COUNT_W'(64);
    map_cols_cfg = COL_COUNT_W'(64);
    next_row     = '0;
    next_col     = '0;
    foreach (window_model[i]) window_model[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_size();
    test_directed_windows();
    test_small_maps();
    test_mid_map_change();
    test_size_limits();
    test_backpressure();
    test_random_phases();
    drain();

    if (expected_windows.size() != 0) error_count = error_count + 1;
    $display("sent %0d samples over %0d map sizes, checked %0d windows",
             samples_sent, size_writes, windows_seen);
    $display("covered default, tiny, clamped and changed sizes, all idle modes, long hold-off");
    if (error_count == 0) begin
      $display("[max_pool_with_argmax_unit] OK");
    end else begin
      $display("%0d failures", error_count);
      $display("[max_pool_with_argmax_unit] ERROR");
    end
    $finish;
  end

endmodule
